/* sv/ledser_pkg.sv */
// shared types, constants and helpers for the led driver frame serializer
package ledser_pkg;

  // default parameter values
  localparam int DEF_MAX_CHIPS         = 1024;
  localparam int DEF_CHANNELS_PER_CHIP = 12;

  // fixed field widths
  localparam int CHIP_COUNT_W = 11;
  localparam int CFG_ONE_W    = 10;
  localparam int CFG_TWO_W    = 3;
  localparam int KIND_W       = 3;
  localparam int VALUE_W      = 16;
  localparam int LEN_W        = 10;
  localparam int FRAME_W      = 48;
  localparam int NBITS_W      = 6;
  localparam int CFG_IDX_W    = 2;

  // packet kinds
  localparam logic [KIND_W-1:0] KIND_GRAY16   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GRAY10   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DOT8     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DOT6     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CONFIG16 = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CONFIG10 = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHIP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_ONE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_TWO   = 2'd2;

  // load request from the framing logic to the shifter
  typedef struct packed {
    logic                 go;
    logic [FRAME_W-1:0]   word;
    logic [NBITS_W-1:0]   nbits;
    logic                 ends;
  } ledser_load_t;

  // command code for each packet kind
  function automatic logic [5:0] cmd_code(input logic [KIND_W-1:0] kind);
    logic [5:0] code;
    unique case (kind)
      KIND_GRAY16:   code = 6'h3f;
      KIND_GRAY10:   code = 6'h2b;
      KIND_DOT8:     code = 6'h33;
      KIND_DOT6:     code = 6'h27;
      KIND_CONFIG16: code = 6'h23;
      KIND_CONFIG10: code = 6'h37;
      default:       code = 6'h00;
    endcase
    return code;
  endfunction

endpackage

/* sv/ledser_framer.sv */
// builds one header or element as a left-aligned bit word and its length
module ledser_framer
  import ledser_pkg::*;
(
  input  logic                  is_header,
  input  logic [KIND_W-1:0]     kind,
  input  logic [VALUE_W-1:0]    value,
  input  logic [LEN_W-1:0]      len,
  input  logic [CFG_ONE_W-1:0]  cf1,
  input  logic [CFG_TWO_W-1:0]  cf2,
  output logic [FRAME_W-1:0]    word,
  output logic [NBITS_W-1:0]    nbits
);

  logic [5:0]         h;
  logic [3:0]         par;
  logic [VALUE_W-1:0] half;

  // parity nibble: length, zero address, command, then parity of those three
  always_comb begin
    h      = cmd_code(kind);
    par[0] = ^len;
    par[1] = 1'b0;
    par[2] = ^h;
    par[3] = ^par[2:0];
    half   = {1'b0, value[VALUE_W-1:1]};
  end

  // header and element layouts, most significant bit first
  always_comb begin
    word  = '0;
    nbits = '0;
    if (is_header) begin
      if (kind == KIND_GRAY16 || kind == KIND_DOT8 || kind == KIND_CONFIG16) begin
        word  = {h, 10'd0, h, len, par, 2'd0, len};
        nbits = 6'd48;
      end else begin
        word  = {h, par, 10'd0, len, 18'd0};
        nbits = 6'd30;
      end
    end else begin
      unique case (kind)
        KIND_GRAY16: begin
          word  = {half, 32'd0};
          nbits = 6'd16;
        end
        KIND_GRAY10: begin
          word  = {half[15:6], 38'd0};
          nbits = 6'd10;
        end
        KIND_DOT8: begin
          word  = {value[7:0], value[7:0], 32'd0};
          nbits = 6'd16;
        end
        KIND_DOT6: begin
          word  = {4'd0, value[5:0], 38'd0};
          nbits = 6'd10;
        end
        KIND_CONFIG16: begin
          word  = {6'd0, cf1, 6'd0, cf1, 13'd0, cf2};
          nbits = 6'd48;
        end
        default: begin
          word  = {cf1, cf1, 7'd0, cf2, 18'd0};
          nbits = 6'd30;
        end
      endcase
    end
  end

endmodule

/* sv/ledser_shifter.sv */
// shared shift register and bit sequencer with registered output stage
module ledser_shifter
  import ledser_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  ledser_load_t  load,
  output logic          ready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,   // [0] serial_bit, [7:1] zero
  output logic          m_tlast,   // run_last
  output logic          m_tuser    // packet_end
);

  typedef enum logic {IDLE, SHIFT} state_t;

  state_t               state;
  logic [FRAME_W-1:0]   sr;
  logic [NBITS_W-1:0]   cnt;
  logic                 ends;
  logic                 out_bit;
  logic                 take;

  assign ready   = (state == IDLE);
  assign take    = !m_tvalid || m_tready;
  assign m_tdata = {7'd0, out_bit};

  // sequencer: load a word, then move one bit a cycle into the output stage while it can take one
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      cnt      <= '0;
      ends     <= 1'b0;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
      m_tuser  <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          // output stage empties once its item is taken
          if (m_tready) begin
            m_tvalid <= 1'b0;
          end
          if (load.go) begin
            sr    <= load.word;
            cnt   <= load.nbits;
            ends  <= load.ends;
            state <= SHIFT;
          end
        end
        SHIFT: begin
          if (take) begin
            m_tvalid <= 1'b1;
            out_bit  <= sr[FRAME_W-1];
            m_tlast  <= (cnt == NBITS_W'(1));
            m_tuser  <= ends && (cnt == NBITS_W'(1));
            sr       <= sr << 1;
            cnt      <= cnt - NBITS_W'(1);
            if (cnt == NBITS_W'(1)) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* sv/led_driver_frame_serializer.sv */
// top level: configuration, packet state and the serial bit stream
//
// channel | handshake            | payload
// s_      | s_tvalid / s_tready  | tdata [2:0] packet_kind, [18:3] value; tuser action
// m_      | m_tvalid / m_tready  | tdata [0] serial_bit; tlast run_last; tuser packet_end
// cfg_    | cfg_we, no wait      | cfg_index register, cfg_data value
//
// a header item is 48 or 30 bits, an element 10, 16, 30 or 48 bits; after the load,
// one bit per cycle moves out of a single 48-bit shift register while m_tready allows.
// an item that makes no bits is taken and changes no state.
// the next item is taken while the last bit still waits in the output stage.
// m_tready low stalls the shifter; reset is synchronous with no clearing pass.
module led_driver_frame_serializer
  import ledser_pkg::*;
#(
  parameter int MAX_CHIPS         = DEF_MAX_CHIPS,
  parameter int CHANNELS_PER_CHIP = DEF_CHANNELS_PER_CHIP
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [23:0]             s_tdata,   // [2:0] packet_kind, [18:3] value, [23:19] zero
  input  logic                    s_tuser,   // action
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [7:0]              m_tdata,   // [0] serial_bit, [7:1] zero
  output logic                    m_tlast,   // run_last
  output logic                    m_tuser,   // packet_end
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CHIP_COUNT_W-1:0] cfg_data
);

  localparam int ELEM_W = $clog2(MAX_CHIPS * CHANNELS_PER_CHIP + 1);

  logic [CHIP_COUNT_W-1:0] chip_count;
  logic [CFG_ONE_W-1:0]    cf1;
  logic [CFG_TWO_W-1:0]    cf2;

  logic                    active;
  logic [KIND_W-1:0]       cur_kind;
  logic [ELEM_W-1:0]       elems;

  logic                    action;
  logic [KIND_W-1:0]       in_kind;
  logic [VALUE_W-1:0]      in_value;
  logic                    accept;
  logic                    start_ok;
  logic                    data_ok;
  logic                    last_elem;
  logic [CHIP_COUNT_W-1:0] chips;
  logic [CHIP_COUNT_W-1:0] len_full;
  logic [LEN_W-1:0]        len;
  logic [ELEM_W-1:0]       start_elems;
  logic [KIND_W-1:0]       frame_kind;
  logic [FRAME_W-1:0]      frame_word;
  logic [NBITS_W-1:0]      frame_nbits;
  ledser_load_t            load;
  logic                    shift_ready;

  // item decode
  assign action   = s_tuser;
  assign in_kind  = s_tdata[2:0];
  assign in_value = s_tdata[18:3];
  assign s_tready = shift_ready;
  assign accept   = s_tvalid && s_tready;
  assign start_ok = !action && (in_kind <= KIND_CONFIG10);
  assign data_ok  = action && active;
  assign last_elem = (elems <= ELEM_W'(1));

  // chain length clamped to the supported range, header length field
  always_comb begin
    chips = chip_count;
    if (chips == '0) begin
      chips = CHIP_COUNT_W'(1);
    end
    if (chips > CHIP_COUNT_W'(MAX_CHIPS)) begin
      chips = CHIP_COUNT_W'(MAX_CHIPS);
    end
    len_full = chips - CHIP_COUNT_W'(1);
    len      = (len_full > CHIP_COUNT_W'(1023)) ? LEN_W'(1023) : len_full[LEN_W-1:0];
    if (in_kind >= KIND_CONFIG16) begin
      start_elems = ELEM_W'(chips);
    end else begin
      start_elems = ELEM_W'(chips) * ELEM_W'(CHANNELS_PER_CHIP);
    end
  end

  assign frame_kind = action ? cur_kind : in_kind;

  ledser_framer u_framer (
    .is_header (!action),
    .kind      (frame_kind),
    .value     (in_value),
    .len       (len),
    .cf1       (cf1),
    .cf2       (cf2),
    .word      (frame_word),
    .nbits     (frame_nbits)
  );

  // load request to the shifter
  assign load = '{go:    accept && (start_ok || data_ok),
                  word:  frame_word,
                  nbits: frame_nbits,
                  ends:  data_ok && last_elem};

  ledser_shifter u_shifter (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .ready    (shift_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chip_count <= CHIP_COUNT_W'(1);
      cf1        <= '0;
      cf2        <= CFG_TWO_W'(7);
    end else if (cfg_we) begin
      if (cfg_index == CFG_CHIP_COUNT) begin
        chip_count <= cfg_data;
      end else if (cfg_index == CFG_WORD_ONE) begin
        cf1 <= cfg_data[CFG_ONE_W-1:0];
      end else if (cfg_index == CFG_WORD_TWO) begin
        cf2 <= cfg_data[CFG_TWO_W-1:0];
      end
    end
  end

  // open packet state and element countdown
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      cur_kind <= '0;
      elems    <= '0;
    end else if (accept) begin
      if (start_ok) begin
        active   <= 1'b1;
        cur_kind <= in_kind;
        elems    <= start_elems;
      end else if (data_ok) begin
        if (elems != '0) begin
          elems <= elems - ELEM_W'(1);
        end
        if (last_elem) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

/* tb/led_driver_frame_serializer_tb.sv */
// self-checking testbench for the led driver frame serializer
`timescale 1ns / 1ps

module led_driver_frame_serializer_tb;
  import ledser_pkg::*;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_DATA  = 1'b1;
  localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  // one serial bit as it leaves the block
  typedef struct packed {
    logic serial_bit;
    logic run_last;
    logic packet_end;
  } led_bit_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [23:0]             s_tdata = '0;   // [2:0] packet_kind, [18:3] value, [23:19] zero
  logic                    s_tuser = 1'b0; // action
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [7:0]              m_tdata;        // [0] serial_bit, [7:1] zero
  logic                    m_tlast;        // run_last
  logic                    m_tuser;        // packet_end
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CHIP_COUNT_W-1:0] cfg_data = '0;

  // predictor copy of registers and packet state
  logic [CHIP_COUNT_W-1:0] chip_count_copy = 11'd1;
  logic [CFG_ONE_W-1:0]    word_one_copy = '0;
  logic [CFG_TWO_W-1:0]    word_two_copy = 3'd7;
  logic                    pkt_open = 1'b0;
  logic [KIND_W-1:0]       pkt_kind = '0;
  int                      elems_left = 0;

  led_bit_t pending_bits[$];
  led_bit_t bit_want;
  led_bit_t bit_got;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int items_with_bits = 0;
  int bits_checked = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  led_driver_frame_serializer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // work out the bits one accepted item must produce
  function automatic void predict_led_bits(input logic act, input logic [KIND_W-1:0] kind,
                                           input logic [VALUE_W-1:0] val);
    logic [FRAME_W-1:0] frame;
    int                 nbits;
    logic               ends;
    int                 chips;
    logic [LEN_W-1:0]   len;
    logic [5:0]         hcode;
    logic [3:0]         par;
    frame = '0;
    nbits = 0;
    ends  = 1'b0;
    chips = (chip_count_copy == 0) ? 1 :
            (chip_count_copy > DEF_MAX_CHIPS) ? DEF_MAX_CHIPS : int'(chip_count_copy);
    if (act == ACT_START) begin
      // reserved kinds leave everything untouched
      if (kind > KIND_CONFIG10) return;
      pkt_kind   = kind;
      elems_left = (kind >= KIND_CONFIG16) ? chips : chips * DEF_CHANNELS_PER_CHIP;
      pkt_open   = 1'b1;
      len = LEN_W'(chips - 1);
      case (kind)
        KIND_GRAY16:   hcode = 6'h3f;
        KIND_GRAY10:   hcode = 6'h2b;
        KIND_DOT8:     hcode = 6'h33;
        KIND_DOT6:     hcode = 6'h27;
        KIND_CONFIG16: hcode = 6'h23;
        default:       hcode = 6'h37;
      endcase
      // address is zero so its parity bit stays clear
      par    = {1'b0, ^hcode, 1'b0, ^len};
      par[3] = ^par[2:0];
      if (kind == KIND_GRAY16 || kind == KIND_DOT8 || kind == KIND_CONFIG16) begin
        frame = {hcode, 10'd0, hcode, len, par, 2'b00, len};
        nbits = 48;
      end else begin
        frame = {18'd0, hcode, par, 10'd0, len};
        nbits = 30;
      end
    end else begin
      // data with no packet open is dropped
      if (!pkt_open) return;
      case (pkt_kind)
        KIND_GRAY16: begin
          frame = {32'd0, 1'b0, val[15:1]};
          nbits = 16;
        end
        KIND_GRAY10: begin
          frame = {38'd0, 1'b0, val[15:7]};
          nbits = 10;
        end
        KIND_DOT8: begin
          frame = {32'd0, val[7:0], val[7:0]};
          nbits = 16;
        end
        KIND_DOT6: begin
          frame = {38'd0, 4'd0, val[5:0]};
          nbits = 10;
        end
        KIND_CONFIG16: begin
          frame = {6'd0, word_one_copy, 6'd0, word_one_copy, 13'd0, word_two_copy};
          nbits = 48;
        end
        default: begin
          frame = {18'd0, word_one_copy, word_one_copy, 7'd0, word_two_copy};
          nbits = 30;
        end
      endcase
      if (elems_left > 0) elems_left--;
      if (elems_left == 0) begin
        ends     = 1'b1;
        pkt_open = 1'b0;
      end
    end
    for (int i = nbits - 1; i >= 0; i--) begin
      pending_bits.push_back('{frame[i], (i == 0), (i == 0) && ends});
    end
    items_with_bits++;
  endfunction

  task automatic report_mismatch(input string what, input led_bit_t want, input led_bit_t got);
    if (mismatches < 10) begin
      $display("%0t: %s: expected bit %0b last %0b end %0b, got bit %0b last %0b end %0b",
               $realtime, what, want.serial_bit, want.run_last, want.packet_end,
               got.serial_bit, got.run_last, got.packet_end);
    end
    mismatches++;
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        bit_got = '{m_tdata[0], m_tlast, m_tuser};
        if (pending_bits.size() == 0) begin
          report_mismatch("bit with nothing expected", '0, bit_got);
        end else begin
          bit_want = pending_bits.pop_front();
          if (bit_got.serial_bit !== bit_want.serial_bit ||
              bit_got.run_last !== bit_want.run_last ||
              bit_got.packet_end !== bit_want.packet_end) begin
            report_mismatch("bit mismatch", bit_want, bit_got);
          end
          bits_checked++;
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // offer one item and wait until it is taken
  task automatic send_led_item(input logic act, input logic [KIND_W-1:0] kind,
                               input logic [VALUE_W-1:0] val);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {5'd0, val, kind};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_led_bits(act, kind, val);
    items_sent++;
  endtask

  // hold off the sender until every expected bit has arrived
  task automatic wait_stream_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_bits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CHIP_COUNT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_CHIP_COUNT: chip_count_copy = data;
      CFG_WORD_ONE:   word_one_copy = data[CFG_ONE_W-1:0];
      default:        word_two_copy = data[CFG_TWO_W-1:0];
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_regs(input int chips, input int one, input int two);
    write_reg(CFG_CHIP_COUNT, CHIP_COUNT_W'(chips));
    write_reg(CFG_WORD_ONE, CHIP_COUNT_W'(one));
    write_reg(CFG_WORD_TWO, CHIP_COUNT_W'(two));
  endtask

  // every kind, stray data, reserved kinds and abandoned packets at reset settings
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_led_item(ACT_DATA, KIND_RSVD_HI, 16'hffff);
    send_led_item(ACT_START, KIND_RSVD_LO, 16'hffff);
    send_led_item(ACT_START, KIND_RSVD_HI, 16'h0000);
    send_led_item(ACT_START, KIND_CONFIG16, 16'h0000);
    send_led_item(ACT_DATA, KIND_RSVD_HI, 16'hffff);
    send_led_item(ACT_START, KIND_CONFIG10, 16'hffff);
    send_led_item(ACT_DATA, KIND_GRAY16, 16'h0000);
    send_led_item(ACT_DATA, KIND_GRAY16, 16'h1234);
    send_led_item(ACT_START, KIND_GRAY16, 16'h0000);
    send_led_item(ACT_DATA, KIND_GRAY16, 16'hffff);
    send_led_item(ACT_DATA, KIND_GRAY16, 16'h0000);
    send_led_item(ACT_START, KIND_GRAY10, 16'h0000);
    send_led_item(ACT_DATA, KIND_GRAY10, 16'hffff);
    send_led_item(ACT_DATA, KIND_GRAY10, 16'h0080);
    send_led_item(ACT_START, KIND_DOT8, 16'h0000);
    send_led_item(ACT_DATA, KIND_DOT8, 16'h00ff);
    send_led_item(ACT_DATA, KIND_DOT8, 16'hff00);
    send_led_item(ACT_START, KIND_DOT6, 16'h0000);
    send_led_item(ACT_DATA, KIND_DOT6, 16'h003f);
    send_led_item(ACT_DATA, KIND_DOT6, 16'hffc0);
    wait_stream_drained();
  endtask

  // chip counts at and past the limits, each kind opened and fed one element
  task automatic test_chip_count_limits();
    int counts[4];
    counts = '{1024, 1025, 2047, 0};
    send_idle_pct  = 7;
    recv_stall_pct = 7;
    write_all_regs(1, 1023, 0);
    foreach (counts[c]) begin
      write_reg(CFG_CHIP_COUNT, CHIP_COUNT_W'(counts[c]));
      for (int k = 0; k <= int'(KIND_CONFIG10); k++) begin
        send_led_item(ACT_START, KIND_W'(k), 16'($urandom));
        send_led_item(ACT_DATA, KIND_W'($urandom_range(7, 0)), 16'($urandom));
      end
      wait_stream_drained();
    end
  endtask

  // mostly complete packets with random content, plus stray and broken sequences
  task automatic run_random_items(input int count);
    int goal;
    int roll;
    int cut;
    goal = items_with_bits + count;
    while (items_with_bits < goal) begin
      roll = $urandom_range(99, 0);
      if (roll < 72) begin
        send_led_item(ACT_START, KIND_W'($urandom_range(5, 0)), 16'($urandom));
        while (pkt_open && items_with_bits < goal) begin
          send_led_item(ACT_DATA, KIND_W'($urandom_range(7, 0)), 16'($urandom));
        end
      end else if (roll < 84) begin
        // packet left open, later abandoned by the next start
        send_led_item(ACT_START, KIND_W'($urandom_range(5, 0)), 16'($urandom));
        cut = $urandom_range(4, 0);
        repeat (cut) send_led_item(ACT_DATA, KIND_W'($urandom_range(7, 0)), 16'($urandom));
      end else if (roll < 91) begin
        send_led_item(ACT_DATA, KIND_W'($urandom_range(7, 0)), 16'($urandom));
      end else if (roll < 97) begin
        send_led_item(ACT_START, $urandom_range(1, 0) ? KIND_RSVD_HI : KIND_RSVD_LO,
                      16'($urandom));
      end else begin
        wait_stream_drained();
      end
    end
  endtask

  // phases cycling through register settings and idle mixes
  task automatic test_random_traffic();
    for (int ph = 0; ph < 8; ph++) begin
      wait_stream_drained();
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 60;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 60;
        end
        default: begin
          send_idle_pct  = 7;
          recv_stall_pct = 7;
        end
      endcase
      case (ph)
        0:       write_all_regs(1, 1023, 0);
        1:       write_all_regs(2, 0, 7);
        2:       write_all_regs(0, $urandom_range(1023, 0), $urandom_range(7, 0));
        3:       write_all_regs(3, $urandom_range(1023, 0), $urandom_range(7, 0));
        default: write_all_regs($urandom_range(3, 1), $urandom_range(1023, 0),
                                $urandom_range(7, 0));
      endcase
      run_random_items(46);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_chip_count_limits();
    test_random_traffic();
    wait_stream_drained();
    $display("sent %0d items (%0d producing bits), checked %0d serial bits",
             items_sent, items_with_bits, bits_checked);
    $display("all six packet kinds, chip counts 0 to 2047, four idle and stall mixes");
    if (mismatches == 0 && pending_bits.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d bits outstanding", mismatches, pending_bits.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* led_driver_frame_serializer.f */
sv/ledser_pkg.sv
sv/ledser_framer.sv
sv/ledser_shifter.sv
sv/led_driver_frame_serializer.sv
tb/led_driver_frame_serializer_tb.sv
